// ===== rtl/bnhs_pkg.sv =====
// Shared types and constants of the backpressure next-hop selector.
// No dependencies; the top level takes names from here by scope.
`timescale 1ns / 1ps

package bnhs_pkg;

  // Item opcodes; codes five to seven are ignored.
  typedef enum logic [2:0] {
    OP_OWN_BACKLOG  = 3'd0,
    OP_NBR_BACKLOG  = 3'd1,
    OP_NBR_ENTRY    = 3'd2,
    OP_DESTINATION  = 3'd3,
    OP_COMPUTE      = 3'd4
  } opcode_t;

  // Configuration register indexes
  localparam logic CFG_OWN_ADDRESS = 1'b0;
  localparam logic CFG_TIE_SEED    = 1'b1;

  localparam int          ADDR_BITS   = 32;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [15:0] SEED_RESET  = 16'd44257;
  localparam int          MAX_ACTIVE  = 16;  // entries that take part in a compute

  // One neighbor table entry
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 two_way;
    logic                 present;
  } nbr_entry_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CREAD = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

endpackage

// ===== rtl/backpressure_next_hop_select_top.sv =====
// Backpressure next-hop selector: table memories, scan controller, tie-break LFSR.
// Depends on bnhs_pkg (opcodes, state type, neighbor entry type, constants).
`timescale 1ns / 1ps

// User notes. After reset the block sweeps its tables to zero with busy
// high; configuration writes are taken during the sweep, items are not. An
// item is taken when start is high and busy is low. Table writes (opcodes 0
// to 3) leave busy low. A compute raises busy and walks the first
// min(16, COMMODITIES) commodities; per commodity it first reads the
// commodity entry and then scans the neighbors, streaming the neighbor
// backlog memory and neighbor table at one entry a cycle, so a commodity
// scans at most min(16, NEIGHBORS) neighbors. It finishes early on a
// present, two-way neighbor that is the destination, and after the first
// neighbor when the commodity is addressed to this node. Each commodity gives
// one result, shown for exactly one cycle with result_strobe; the receiver
// cannot stall, so it must take every strobed result. last_result marks the
// final one, and busy is already low in the cycle that shows it. cfg_ready is
// always high; write configuration only while busy is low.
module backpressure_next_hop_select_top #(
  parameter int COMMODITIES  = 16,
  parameter int NEIGHBORS    = 16,
  parameter int BACKLOG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [3:0]  commodity_index,
  input  logic [3:0]  neighbor_index,
  input  logic [15:0] backlog_value,
  input  logic [31:0] node_address,
  input  logic        two_way,
  input  logic        present,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // results
  output logic        result_strobe,
  output logic [3:0]  result_commodity,
  output logic        route_valid,
  output logic [3:0]  next_hop_index,
  output logic [31:0] next_hop_address,
  output logic [31:0] destination_address,
  output logic [15:0] max_differential,
  output logic        last_result
);

  localparam int CI_W   = (COMMODITIES > 1) ? $clog2(COMMODITIES) : 1;
  localparam int NI_W   = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int NB     = NEIGHBORS * COMMODITIES;
  localparam int NB_W   = (NB > 1) ? $clog2(NB) : 1;
  localparam int BB     = BACKLOG_BITS;
  localparam int ACT_C  = (COMMODITIES < bnhs_pkg::MAX_ACTIVE) ? COMMODITIES
                                                              : bnhs_pkg::MAX_ACTIVE;
  localparam int ACT_N  = (NEIGHBORS < bnhs_pkg::MAX_ACTIVE) ? NEIGHBORS
                                                            : bnhs_pkg::MAX_ACTIVE;
  localparam logic [CI_W-1:0] LAST_C = CI_W'(ACT_C - 1);
  localparam logic [NI_W-1:0] LAST_N = NI_W'(ACT_N - 1);
  localparam logic [NB_W-1:0] LAST_CLR = NB_W'(NB - 1);
  localparam logic [NB_W:0]   C_STEP = (NB_W + 1)'(COMMODITIES);

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  bnhs_pkg::state_t state, state_next;
  logic [NB_W-1:0]  clr_cnt;
  logic [CI_W-1:0]  cidx;
  logic [NI_W-1:0]  nidx;
  logic [NB_W:0]    nb_ptr;
  logic [31:0]      own_address;
  logic [15:0]      lfsr;

  // per-commodity search state
  logic             found;
  logic [NI_W-1:0]  best_n;
  logic [BB-1:0]    best_d;
  logic [31:0]      best_addr;
  logic [4:0]       count;

  // ---------------------------------------------------------------------
  // Table memories (one write port, one registered read port each)
  // ---------------------------------------------------------------------
  logic [BB-1:0]              ob_mem   [COMMODITIES];
  logic [31:0]                dest_mem [COMMODITIES];
  logic [BB-1:0]              nb_mem   [NB];
  bnhs_pkg::nbr_entry_t       nbr_mem  [NEIGHBORS];

  logic [BB-1:0]              ob_q;
  logic [31:0]                dest_q;
  logic [BB-1:0]              nb_q;
  bnhs_pkg::nbr_entry_t       nbr_q;

  logic item_take;
  logic clr_we;
  logic ob_we, nb_we, nbr_we, dest_we;
  logic cread;
  logic scan_rd;
  logic [CI_W-1:0] wr_ci;
  logic [NI_W-1:0] wr_ni;
  logic [NB_W-1:0] wr_nb;
  logic [BB-1:0]   wr_backlog;
  logic [NI_W-1:0] nbr_raddr;
  logic [NB_W-1:0] nb_raddr;
  bnhs_pkg::nbr_entry_t wr_entry;

  assign busy      = (state != bnhs_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign item_take = start && !busy;
  assign clr_we    = (state == bnhs_pkg::ST_CLEAR);
  assign cread     = (state == bnhs_pkg::ST_CREAD);

  // Decode table writes; drop indexes beyond the tables.
  always_comb begin
    logic ci_ok;
    logic ni_ok;
    ci_ok   = (32'(commodity_index) < COMMODITIES);
    ni_ok   = (32'(neighbor_index) < NEIGHBORS);
    ob_we   = item_take && (opcode == bnhs_pkg::OP_OWN_BACKLOG) && ci_ok;
    nb_we   = item_take && (opcode == bnhs_pkg::OP_NBR_BACKLOG) && ci_ok && ni_ok;
    nbr_we  = item_take && (opcode == bnhs_pkg::OP_NBR_ENTRY) && ni_ok;
    dest_we = item_take && (opcode == bnhs_pkg::OP_DESTINATION) && ci_ok;
  end

  assign wr_ci      = CI_W'(commodity_index);
  assign wr_ni      = NI_W'(neighbor_index);
  assign wr_nb      = NB_W'(32'(neighbor_index) * COMMODITIES + 32'(commodity_index));
  assign wr_backlog = BB'(backlog_value);
  assign wr_entry   = '{addr: node_address, two_way: two_way, present: present};

  // Neighbor reads: entry 0 with the commodity read, then one ahead each scan cycle.
  assign scan_rd   = (state == bnhs_pkg::ST_SCAN) && (nidx != LAST_N);
  assign nbr_raddr = cread ? '0 : NI_W'(nidx + NI_W'(1));
  assign nb_raddr  = cread ? NB_W'(cidx) : nb_ptr[NB_W-1:0];

  always_ff @(posedge clk) begin
    if (clr_we) begin
      ob_mem[clr_cnt[CI_W-1:0]] <= '0;
    end else if (ob_we) begin
      ob_mem[wr_ci] <= wr_backlog;
    end
    if (cread) begin
      ob_q <= ob_mem[cidx];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      dest_mem[clr_cnt[CI_W-1:0]] <= '0;
    end else if (dest_we) begin
      dest_mem[wr_ci] <= node_address;
    end
    if (cread) begin
      dest_q <= dest_mem[cidx];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      nb_mem[clr_cnt] <= '0;
    end else if (nb_we) begin
      nb_mem[wr_nb] <= wr_backlog;
    end
    if (cread || scan_rd) begin
      nb_q <= nb_mem[nb_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      nbr_mem[clr_cnt[NI_W-1:0]] <= '0;
    end else if (nbr_we) begin
      nbr_mem[wr_ni] <= wr_entry;
    end
    if (cread || scan_rd) begin
      nbr_q <= nbr_mem[nbr_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Per-neighbor evaluation: data for neighbor nidx sits in nb_q / nbr_q.
  // ---------------------------------------------------------------------
  logic [BB-1:0]   diff;
  logic            eligible;
  logic            hit;
  logic            contend;
  logic [4:0]      count_step;
  logic [15:0]     lfsr_step;
  logic [20:0]     prod;
  logic            take;
  logic            own_route;
  logic            cdone;
  logic            found_n;
  logic [NI_W-1:0] best_n_n;
  logic [BB-1:0]   best_d_n;
  logic [31:0]     best_addr_n;

  always_comb begin
    diff       = (ob_q >= nb_q) ? BB'(ob_q - nb_q) : '0;
    eligible   = nbr_q.present && nbr_q.two_way;
    hit        = eligible && (nbr_q.addr == dest_q);
    contend    = eligible && !hit && !(diff < best_d);
    count_step = (diff == best_d) ? 5'(count + 5'd1) : 5'd1;
    lfsr_step  = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? bnhs_pkg::LFSR_TAPS : 16'd0);
    prod       = 21'(lfsr_step) * 21'(count_step);
    take       = hit || (contend && (prod[20:16] == 5'd0));
    own_route  = (dest_q == own_address);
    cdone      = own_route || hit || (nidx == LAST_N);
    found_n    = found || take;
    best_n_n   = take ? nidx : best_n;
    best_d_n   = take ? diff : best_d;
    best_addr_n = take ? nbr_q.addr : best_addr;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      bnhs_pkg::ST_CLEAR: begin
        if (clr_cnt == LAST_CLR) state_next = bnhs_pkg::ST_IDLE;
      end
      bnhs_pkg::ST_IDLE: begin
        if (item_take && opcode == bnhs_pkg::OP_COMPUTE) state_next = bnhs_pkg::ST_CREAD;
      end
      bnhs_pkg::ST_CREAD: begin
        state_next = bnhs_pkg::ST_SCAN;
      end
      bnhs_pkg::ST_SCAN: begin
        if (cdone) begin
          state_next = (cidx == LAST_C) ? bnhs_pkg::ST_IDLE : bnhs_pkg::ST_CREAD;
        end
      end
      default: state_next = bnhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bnhs_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      cidx          <= '0;
      nidx          <= '0;
      nb_ptr        <= '0;
      own_address   <= '0;
      lfsr          <= bnhs_pkg::SEED_RESET;
      found         <= 1'b0;
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;

      if (clr_we) clr_cnt <= NB_W'(clr_cnt + NB_W'(1));

      // Configuration: tie_seed write also reloads the generator.
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == bnhs_pkg::CFG_OWN_ADDRESS) begin
          own_address <= cfg_data;
        end else if (cfg_index == bnhs_pkg::CFG_TIE_SEED) begin
          lfsr <= cfg_data[15:0];
        end
      end

      if (item_take && opcode == bnhs_pkg::OP_COMPUTE) begin
        cidx <= '0;
      end

      // Open a commodity: clear the search, point at neighbor one.
      if (cread) begin
        nidx   <= '0;
        nb_ptr <= (NB_W + 1)'((NB_W + 1)'(cidx) + C_STEP);
        found  <= 1'b0;
        count  <= '0;
        best_d <= '0;
      end

      if (state == bnhs_pkg::ST_SCAN) begin
        // Advance the read pointer with the stream.
        nidx   <= NI_W'(nidx + NI_W'(1));
        nb_ptr <= (NB_W + 1)'(nb_ptr + C_STEP);
        if (!own_route) begin
          if (contend) begin
            lfsr  <= lfsr_step;
            count <= count_step;
          end
          found     <= found_n;
          best_n    <= best_n_n;
          best_d    <= best_d_n;
          best_addr <= best_addr_n;
        end
        if (cdone) begin
          result_strobe <= 1'b1;
          cidx          <= CI_W'(cidx + CI_W'(1));
        end
      end
    end
  end

  // Result payload: load when a commodity closes.
  always_ff @(posedge clk) begin
    if (state == bnhs_pkg::ST_SCAN && cdone) begin
      result_commodity    <= 4'(cidx);
      destination_address <= dest_q;
      last_result         <= (cidx == LAST_C);
      if (!own_route && found_n) begin
        route_valid      <= 1'b1;
        next_hop_index   <= 4'(best_n_n);
        next_hop_address <= best_addr_n;
        max_differential <= (32'(best_d_n) > 32'h0000_FFFF) ? 16'hFFFF : 16'(best_d_n);
      end else begin
        route_valid      <= 1'b0;
        next_hop_index   <= '0;
        next_hop_address <= '0;
        max_differential <= '0;
      end
    end
  end

endmodule
